/* rtl/dll_pkg.sv */
`default_nettype none

package dll_pkg;

   // pool and list geometry
   localparam int POOL_NODES = 1024;
   localparam int LIST_COUNT = 4;
   localparam int NODE_W     = 10;
   localparam int PTR_W      = 11;
   localparam int CNT_W      = 11;
   localparam int LIST_W     = 2;
   localparam int OP_W       = 4;
   localparam int ST_W       = 2;

   // link value meaning no neighbour
   localparam logic [PTR_W-1:0] NO_LINK = PTR_W'(POOL_NODES);
   localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_NODES);

   // opcodes
   localparam logic [OP_W-1:0] OP_APPEND   = 4'd0;
   localparam logic [OP_W-1:0] OP_INSERT   = 4'd1;
   localparam logic [OP_W-1:0] OP_DEL_NODE = 4'd2;
   localparam logic [OP_W-1:0] OP_DEL_HEAD = 4'd3;
   localparam logic [OP_W-1:0] OP_DEL_TAIL = 4'd4;
   localparam logic [OP_W-1:0] OP_HEAD     = 4'd5;
   localparam logic [OP_W-1:0] OP_TAIL     = 4'd6;
   localparam logic [OP_W-1:0] OP_NTH      = 4'd7;
   localparam logic [OP_W-1:0] OP_NEXT     = 4'd8;
   localparam logic [OP_W-1:0] OP_PREV     = 4'd9;
   localparam logic [OP_W-1:0] OP_COUNT    = 4'd10;
   localparam logic [OP_W-1:0] OP_CLEAR    = 4'd11;
   localparam logic [OP_W-1:0] OP_CHECK    = 4'd12;
   localparam logic [OP_W-1:0] OP_FILL     = 4'd13;

   // response status codes
   localparam logic [ST_W-1:0] ST_OK   = 2'd0;
   localparam logic [ST_W-1:0] ST_NONE = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_IMM,
      CMD_ADD_A,
      CMD_ADD_B,
      CMD_UNL_RD,
      CMD_UNL_WR,
      CMD_NB_RD,
      CMD_NB_RESP,
      CMD_WALK_INIT,
      CMD_WALK_STEP,
      CMD_WALK_LOAD,
      CMD_WALK_TURN,
      CMD_WALK_RESP,
      CMD_FILL_INIT,
      CMD_FILL_STEP
   } cmd_type;

   typedef struct packed {
      cmd_type code;
      logic    respond;
   } ctl_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            len_zero;
      logic            len_full;
      logic            pos_in_range;
      logic            cur_none;
      logic            walk_bound;
      logic            walk_match;
      logic            walk_dir;
      logic            fill_done;
      logic            out_free;
   } sts_type;

   function automatic logic [PTR_W-1:0] norm_link(input logic [PTR_W-1:0] v);
      norm_link = (v >= NO_LINK) ? NO_LINK : v;
   endfunction

endpackage

`default_nettype wire

/* rtl/dll_datapath.sv */
`default_nettype none

module dll_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  [dll_pkg::OP_W-1:0]         req_opcode,
   input  wire  [dll_pkg::LIST_W-1:0]       req_list_id,
   input  wire  [dll_pkg::NODE_W-1:0]       req_node_index,
   input  wire  [dll_pkg::CNT_W-1:0]        req_position,
   input  dll_pkg::ctl_type                 ctl,
   output dll_pkg::sts_type                 sts,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [dll_pkg::ST_W-1:0]         rsp_status,
   output logic [dll_pkg::NODE_W-1:0]       rsp_result_node,
   output logic [dll_pkg::CNT_W-1:0]        rsp_list_count
);

   localparam int PW = dll_pkg::PTR_W;
   localparam int NW = dll_pkg::NODE_W;
   localparam int CW = dll_pkg::CNT_W;
   localparam int LC = dll_pkg::LIST_COUNT;

   logic [dll_pkg::OP_W-1:0]   op_ff, op_in;
   logic [dll_pkg::LIST_W-1:0] lid_ff, lid_in;
   logic [NW-1:0]              node_ff, node_in;
   logic [CW-1:0]              pos_ff, pos_in;
   logic [NW-1:0]              head_ff [LC];
   logic [NW-1:0]              head_in [LC];
   logic [NW-1:0]              tail_ff [LC];
   logic [NW-1:0]              tail_in [LC];
   logic [CW-1:0]              len_ff  [LC];
   logic [CW-1:0]              len_in  [LC];
   logic [PW-1:0]              cur_ff, cur_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       dir_ff, dir_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dll_pkg::ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [NW-1:0]              rsp_result_ff, rsp_result_in;
   logic [CW-1:0]              rsp_count_ff, rsp_count_in;

   logic [PW-1:0] next_link_mem [dll_pkg::POOL_NODES];
   logic [PW-1:0] prev_link_mem [dll_pkg::POOL_NODES];
   logic [PW-1:0] nx_rd_ff, pv_rd_ff;
   logic          rd_en;
   logic [NW-1:0] rd_addr;
   logic          nx_we, pv_we;
   logic [NW-1:0] nx_waddr, pv_waddr;
   logic [PW-1:0] nx_wdata, pv_wdata;

   logic [NW-1:0] h, t, target, head_new, tail_new;
   logic [CW-1:0] len, len_new, room, fill_n, walk_limit;
   logic [PW-1:0] nx_n, pv_n, nb;
   logic          hdr_we;
   logic [dll_pkg::ST_W-1:0] st_new;
   logic [NW-1:0] res_new;

   always_comb begin
      h = head_ff[lid_ff];
      t = tail_ff[lid_ff];
      len = len_ff[lid_ff];
      nx_n = dll_pkg::norm_link(nx_rd_ff);
      pv_n = dll_pkg::norm_link(pv_rd_ff);
      nb = (op_ff == dll_pkg::OP_NEXT) ? nx_n : pv_n;
      room = dll_pkg::POOL_CNT - {1'b0, node_ff};
      fill_n = (pos_ff < room) ? pos_ff : room;
      walk_limit = (op_ff == dll_pkg::OP_NTH) ? pos_ff : len;
      case (op_ff)
         dll_pkg::OP_DEL_HEAD: target = h;
         dll_pkg::OP_DEL_TAIL: target = t;
         default:              target = node_ff;
      endcase
   end

   always_comb begin
      sts.op           = op_ff;
      sts.len_zero     = (len == '0);
      sts.len_full     = (len >= dll_pkg::POOL_CNT);
      sts.pos_in_range = (pos_ff < len);
      sts.cur_none     = (cur_ff == dll_pkg::NO_LINK);
      sts.walk_bound   = (cnt_ff >= walk_limit);
      sts.walk_match   = (cnt_ff == len);
      sts.walk_dir     = dir_ff;
      sts.fill_done    = (cnt_ff == '0);
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      op_in    = op_ff;
      lid_in   = lid_ff;
      node_in  = node_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      cnt_in   = cnt_ff;
      dir_in   = dir_ff;
      head_new = h;
      tail_new = t;
      len_new  = len;
      hdr_we   = 1'b0;
      st_new   = dll_pkg::ST_NONE;
      res_new  = '0;
      rd_en    = 1'b0;
      rd_addr  = node_ff;
      nx_we    = 1'b0;
      nx_waddr = node_ff;
      nx_wdata = dll_pkg::NO_LINK;
      pv_we    = 1'b0;
      pv_waddr = node_ff;
      pv_wdata = dll_pkg::NO_LINK;

      case (ctl.code)
         dll_pkg::CMD_LOAD: begin
            op_in   = req_opcode;
            lid_in  = req_list_id;
            node_in = req_node_index;
            pos_in  = req_position;
         end
         dll_pkg::CMD_IMM: begin
            case (op_ff)
               dll_pkg::OP_HEAD: begin
                  if (len != '0) begin
                     st_new  = dll_pkg::ST_OK;
                     res_new = h;
                  end
               end
               dll_pkg::OP_TAIL: begin
                  if (len != '0) begin
                     st_new  = dll_pkg::ST_OK;
                     res_new = t;
                  end
               end
               dll_pkg::OP_COUNT, dll_pkg::OP_FILL: st_new = dll_pkg::ST_OK;
               dll_pkg::OP_CLEAR: begin
                  head_new = '0;
                  tail_new = '0;
                  len_new  = '0;
                  hdr_we   = 1'b1;
                  st_new   = dll_pkg::ST_OK;
               end
               default: st_new = dll_pkg::ST_NONE;
            endcase
         end
         dll_pkg::CMD_ADD_A: begin
            if (op_ff == dll_pkg::OP_APPEND) begin
               nx_we    = (len != '0);
               nx_waddr = t;
               nx_wdata = {1'b0, node_ff};
               pv_we    = 1'b1;
               pv_waddr = node_ff;
               pv_wdata = (len == '0) ? dll_pkg::NO_LINK : {1'b0, t};
            end else begin
               pv_we    = (len != '0);
               pv_waddr = h;
               pv_wdata = {1'b0, node_ff};
               nx_we    = 1'b1;
               nx_waddr = node_ff;
               nx_wdata = (len == '0) ? dll_pkg::NO_LINK : {1'b0, h};
            end
         end
         dll_pkg::CMD_ADD_B: begin
            if (op_ff == dll_pkg::OP_APPEND) begin
               nx_we    = 1'b1;
               tail_new = node_ff;
               if (len == '0) head_new = node_ff;
            end else begin
               pv_we    = 1'b1;
               head_new = node_ff;
               if (len == '0) tail_new = node_ff;
            end
            len_new = len + 1'b1;
            hdr_we  = 1'b1;
            st_new  = dll_pkg::ST_OK;
            res_new = node_ff;
         end
         dll_pkg::CMD_UNL_RD: begin
            rd_en   = 1'b1;
            rd_addr = target;
            cur_in  = {1'b0, target};
         end
         dll_pkg::CMD_UNL_WR: begin
            nx_we    = (pv_n != dll_pkg::NO_LINK);
            nx_waddr = pv_n[NW-1:0];
            nx_wdata = nx_n;
            pv_we    = (nx_n != dll_pkg::NO_LINK);
            pv_waddr = nx_n[NW-1:0];
            pv_wdata = pv_n;
            if (pv_n == dll_pkg::NO_LINK && nx_n != dll_pkg::NO_LINK) head_new = nx_n[NW-1:0];
            if (nx_n == dll_pkg::NO_LINK && pv_n != dll_pkg::NO_LINK) tail_new = pv_n[NW-1:0];
            len_new = len - 1'b1;
            hdr_we  = 1'b1;
            if (op_ff == dll_pkg::OP_DEL_NODE) begin
               if (nx_n != dll_pkg::NO_LINK) begin
                  st_new  = dll_pkg::ST_OK;
                  res_new = nx_n[NW-1:0];
               end
            end else begin
               st_new  = dll_pkg::ST_OK;
               res_new = cur_ff[NW-1:0];
            end
         end
         dll_pkg::CMD_NB_RD: begin
            rd_en   = 1'b1;
            rd_addr = node_ff;
         end
         dll_pkg::CMD_NB_RESP: begin
            if (nb != dll_pkg::NO_LINK) begin
               st_new  = dll_pkg::ST_OK;
               res_new = nb[NW-1:0];
            end
         end
         dll_pkg::CMD_WALK_INIT: begin
            dir_in = 1'b0;
            cnt_in = '0;
            cur_in = (len == '0) ? dll_pkg::NO_LINK : {1'b0, h};
         end
         dll_pkg::CMD_WALK_STEP: begin
            rd_en   = 1'b1;
            rd_addr = cur_ff[NW-1:0];
            cnt_in  = cnt_ff + 1'b1;
         end
         dll_pkg::CMD_WALK_LOAD: cur_in = dir_ff ? pv_n : nx_n;
         dll_pkg::CMD_WALK_TURN: begin
            dir_in = 1'b1;
            cnt_in = '0;
            cur_in = (len == '0) ? dll_pkg::NO_LINK : {1'b0, t};
         end
         dll_pkg::CMD_WALK_RESP: begin
            if (op_ff == dll_pkg::OP_NTH) begin
               if (cur_ff != dll_pkg::NO_LINK) begin
                  st_new  = dll_pkg::ST_OK;
                  res_new = cur_ff[NW-1:0];
               end
            end else begin
               st_new = (cur_ff == dll_pkg::NO_LINK && cnt_ff == len) ?
                        dll_pkg::ST_OK : dll_pkg::ST_BAD;
            end
         end
         dll_pkg::CMD_FILL_INIT: begin
            cnt_in   = fill_n;
            cur_in   = {1'b0, node_ff};
            head_new = (fill_n == '0) ? '0 : node_ff;
            tail_new = '0;
            len_new  = '0;
            hdr_we   = 1'b1;
         end
         dll_pkg::CMD_FILL_STEP: begin
            pv_we    = 1'b1;
            pv_waddr = cur_ff[NW-1:0];
            pv_wdata = (cur_ff == {1'b0, node_ff}) ? dll_pkg::NO_LINK : cur_ff - 1'b1;
            nx_we    = 1'b1;
            nx_waddr = cur_ff[NW-1:0];
            nx_wdata = (cnt_ff == CW'(1)) ? dll_pkg::NO_LINK : cur_ff + 1'b1;
            tail_new = cur_ff[NW-1:0];
            len_new  = len + 1'b1;
            hdr_we   = 1'b1;
            cur_in   = cur_ff + 1'b1;
            cnt_in   = cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      len_in  = len_ff;
      if (hdr_we) begin
         head_in[lid_ff] = head_new;
         tail_in[lid_ff] = tail_new;
         len_in[lid_ff]  = len_new;
      end
   end

   always_comb begin
      rsp_valid_in  = ctl.respond || (rsp_valid_ff && rsp_stall);
      rsp_status_in = ctl.respond ? st_new : rsp_status_ff;
      rsp_result_in = ctl.respond ? res_new : rsp_result_ff;
      rsp_count_in  = ctl.respond ? len_new : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      node_ff       <= node_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      dir_ff        <= dir_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         lid_ff       <= '0;
         for (int i = 0; i < LC; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            len_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         lid_ff       <= lid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (nx_we) next_link_mem[nx_waddr] <= nx_wdata;
      if (rd_en) nx_rd_ff <= next_link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pv_we) prev_link_mem[pv_waddr] <= pv_wdata;
      if (rd_en) pv_rd_ff <= prev_link_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_node = rsp_result_ff;
   assign rsp_list_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_respond_free: assert property (@(posedge clock) disable iff (reset)
      ctl.respond |-> sts.out_free)
      else $error("response issued while output slot occupied");

   a_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != dll_pkg::ST_OK) |-> rsp_result_ff == '0)
      else $error("non-zero result node with failing status");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff[lid_ff] <= dll_pkg::POOL_CNT)
      else $error("list length beyond pool size");
`endif

endmodule

`default_nettype wire

/* rtl/dll_controller.sv */
`default_nettype none

module dll_controller (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  dll_pkg::sts_type sts,
   output dll_pkg::ctl_type ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD_B,
      S_UNL_WR,
      S_NB_RESP,
      S_WALK_STEP,
      S_WALK_LOAD,
      S_FILL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl.code = dll_pkg::CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.code = dll_pkg::CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.op)
               dll_pkg::OP_APPEND, dll_pkg::OP_INSERT: begin
                  if (!sts.len_full) begin
                     ctl.code = dll_pkg::CMD_ADD_A;
                     state_in = S_ADD_B;
                  end else if (sts.out_free) begin
                     ctl.code = dll_pkg::CMD_IMM;
                     state_in = S_IDLE;
                  end
               end
               dll_pkg::OP_DEL_NODE, dll_pkg::OP_DEL_HEAD, dll_pkg::OP_DEL_TAIL: begin
                  if (!sts.len_zero) begin
                     ctl.code = dll_pkg::CMD_UNL_RD;
                     state_in = S_UNL_WR;
                  end else if (sts.out_free) begin
                     ctl.code = dll_pkg::CMD_IMM;
                     state_in = S_IDLE;
                  end
               end
               dll_pkg::OP_NEXT, dll_pkg::OP_PREV: begin
                  ctl.code = dll_pkg::CMD_NB_RD;
                  state_in = S_NB_RESP;
               end
               dll_pkg::OP_NTH: begin
                  if (sts.pos_in_range) begin
                     ctl.code = dll_pkg::CMD_WALK_INIT;
                     state_in = S_WALK_STEP;
                  end else if (sts.out_free) begin
                     ctl.code = dll_pkg::CMD_IMM;
                     state_in = S_IDLE;
                  end
               end
               dll_pkg::OP_CHECK: begin
                  ctl.code = dll_pkg::CMD_WALK_INIT;
                  state_in = S_WALK_STEP;
               end
               dll_pkg::OP_FILL: begin
                  ctl.code = dll_pkg::CMD_FILL_INIT;
                  state_in = S_FILL;
               end
               default: begin
                  if (sts.out_free) begin
                     ctl.code = dll_pkg::CMD_IMM;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_ADD_B: begin
            if (sts.out_free) begin
               ctl.code = dll_pkg::CMD_ADD_B;
               state_in = S_IDLE;
            end
         end
         S_UNL_WR: begin
            if (sts.out_free) begin
               ctl.code = dll_pkg::CMD_UNL_WR;
               state_in = S_IDLE;
            end
         end
         S_NB_RESP: begin
            if (sts.out_free) begin
               ctl.code = dll_pkg::CMD_NB_RESP;
               state_in = S_IDLE;
            end
         end
         S_WALK_STEP: begin
            if (sts.op == dll_pkg::OP_CHECK && sts.cur_none && sts.walk_match
                && !sts.walk_dir) begin
               ctl.code = dll_pkg::CMD_WALK_TURN;
            end else if (sts.cur_none || sts.walk_bound) begin
               if (sts.out_free) begin
                  ctl.code = dll_pkg::CMD_WALK_RESP;
                  state_in = S_IDLE;
               end
            end else begin
               ctl.code = dll_pkg::CMD_WALK_STEP;
               state_in = S_WALK_LOAD;
            end
         end
         S_WALK_LOAD: begin
            ctl.code = dll_pkg::CMD_WALK_LOAD;
            state_in = S_WALK_STEP;
         end
         S_FILL: begin
            if (!sts.fill_done) begin
               ctl.code = dll_pkg::CMD_FILL_STEP;
            end else if (sts.out_free) begin
               ctl.code = dll_pkg::CMD_IMM;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ctl.respond = (ctl.code == dll_pkg::CMD_IMM) || (ctl.code == dll_pkg::CMD_ADD_B) ||
                    (ctl.code == dll_pkg::CMD_UNL_WR) || (ctl.code == dll_pkg::CMD_NB_RESP) ||
                    (ctl.code == dll_pkg::CMD_WALK_RESP);
      req_stall = (state_ff != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/doubly_linked_list_engine.sv */
// doubly linked list engine: four lists share a pool of 1024 node indices
// request channel: req_valid/req_stall carry opcode, list id, node index and
//   position; a transaction is taken when req_valid is high and req_stall low
// response channel: rsp_valid/rsp_stall carry status, result node and the
//   list count; exactly one response transaction per request transaction
// one request is in flight at a time; req_stall is low only in the idle state
// path from request to response register:
//   head, tail, count, clear and refused operations: list headers only
//   append, insert, delete, next and prev: through a link memory access
//   nth: walks next links from the head, reading then loading each link
//   check: walks next links, then prev links if the forward walk matched
//   fill: one node linked per cycle
// link memories have one write and one registered read port each
// reset (synchronous) empties all list headers; link memories are not
//   cleared; the user must read them only once written (not enforced)
// a stalled response holds; the engine then waits before issuing its next
//   response, while the pending response stays stable on the outputs
`default_nettype none

module doubly_linked_list_engine (
   input  wire                          clock,
   input  wire                          reset,
   // request transaction
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [dll_pkg::OP_W-1:0]     req_opcode,
   input  wire  [dll_pkg::LIST_W-1:0]   req_list_id,
   input  wire  [dll_pkg::NODE_W-1:0]   req_node_index,
   input  wire  [dll_pkg::CNT_W-1:0]    req_position,
   // response transaction
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [dll_pkg::ST_W-1:0]     rsp_status,
   output logic [dll_pkg::NODE_W-1:0]   rsp_result_node,
   output logic [dll_pkg::CNT_W-1:0]    rsp_list_count
);

   // command and status between sequencer and datapath
   dll_pkg::ctl_type ctl;
   dll_pkg::sts_type sts;

   // sequencer: dispatch, link update steps, walks and fill loop
   dll_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   // datapath: list headers, link memories, walk registers, response register
   dll_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_list_id     (req_list_id),
      .req_node_index  (req_node_index),
      .req_position    (req_position),
      .ctl             (ctl),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_node (rsp_result_node),
      .rsp_list_count  (rsp_list_count)
   );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_W       = dll_pkg::OP_W;
   localparam int LIST_W     = dll_pkg::LIST_W;
   localparam int NODE_W     = dll_pkg::NODE_W;
   localparam int CNT_W      = dll_pkg::CNT_W;
   localparam int ST_W       = dll_pkg::ST_W;
   localparam int PTR_W      = dll_pkg::PTR_W;
   localparam int POOL_NODES = dll_pkg::POOL_NODES;
   localparam int LIST_COUNT = dll_pkg::LIST_COUNT;

   // one request transaction as handed to the driver
   typedef struct {
      logic [OP_W-1:0]   op;
      logic [LIST_W-1:0] lid;
      logic [NODE_W-1:0] node;
      logic [CNT_W-1:0]  pos;
   } list_req_type;

   // one response transaction as the engine should return it
   typedef struct {
      logic [ST_W-1:0]   st;
      logic [NODE_W-1:0] node;
      logic [CNT_W-1:0]  cnt;
   } list_rsp_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [LIST_W-1:0]   req_list_id = '0;
   logic [NODE_W-1:0]   req_node_index = '0;
   logic [CNT_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ST_W-1:0]     rsp_status;
   logic [NODE_W-1:0]   rsp_result_node;
   logic [CNT_W-1:0]    rsp_list_count;

   doubly_linked_list_engine u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_list_id     (req_list_id),
      .req_node_index  (req_node_index),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_node (rsp_result_node),
      .rsp_list_count  (rsp_list_count)
   );

   // mirror of the list headers and link memories
   logic [NODE_W-1:0] sh_head [LIST_COUNT];
   logic [NODE_W-1:0] sh_tail [LIST_COUNT];
   logic [CNT_W-1:0]  sh_len  [LIST_COUNT];
   logic [PTR_W-1:0]  sh_next [POOL_NODES];
   logic [PTR_W-1:0]  sh_prev [POOL_NODES];
   bit                sh_linked [POOL_NODES];
   int                linked_nodes[$];   // every node whose links have been written

   list_req_type pending_reqs[$];
   list_rsp_type expected_rsps[$];
   list_req_type in_flight;
   int        n_queued = 0;
   int        n_taken = 0;
   int        errors = 0;
   bit        quiet = 1'b0;             // no gaps and no stalls while set
   int        req_gap = 0;
   int        stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      #200_000_000;
      $display("FAIL doubly_linked_list_engine");
      $finish;
   end

   // mostly short idles, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [PTR_W-1:0] as_link(logic [PTR_W-1:0] v);
      return (v >= dll_pkg::NO_LINK) ? dll_pkg::NO_LINK : v;
   endfunction

   function automatic void note_linked(int n);
      if (!sh_linked[n]) begin
         sh_linked[n] = 1'b1;
         linked_nodes.push_back(n);
      end
   endfunction

   function automatic void push_tail(int l, int n);
      if (sh_len[l] == 0) begin
         sh_prev[n] = dll_pkg::NO_LINK;
         sh_head[l] = NODE_W'(n);
      end else begin
         sh_prev[n] = PTR_W'(sh_tail[l]);
         sh_next[sh_tail[l]] = PTR_W'(n);
      end
      sh_next[n] = dll_pkg::NO_LINK;
      sh_tail[l] = NODE_W'(n);
      sh_len[l]++;
      note_linked(n);
   endfunction

   function automatic void push_head(int l, int n);
      if (sh_len[l] == 0) begin
         sh_next[n] = dll_pkg::NO_LINK;
         sh_tail[l] = NODE_W'(n);
      end else begin
         sh_next[n] = PTR_W'(sh_head[l]);
         sh_prev[sh_head[l]] = PTR_W'(n);
      end
      sh_prev[n] = dll_pkg::NO_LINK;
      sh_head[l] = NODE_W'(n);
      sh_len[l]++;
      note_linked(n);
   endfunction

   // takes a node out of a list, gives back its successor
   function automatic logic [PTR_W-1:0] cut_node(int l, int n);
      logic [PTR_W-1:0] p;
      logic [PTR_W-1:0] s;
      p = as_link(sh_prev[n]);
      s = as_link(sh_next[n]);
      sh_len[l]--;
      if (p == dll_pkg::NO_LINK) begin
         if (s != dll_pkg::NO_LINK) sh_head[l] = s[NODE_W-1:0];
      end else begin
         sh_next[p] = s;
      end
      if (s == dll_pkg::NO_LINK) begin
         if (p != dll_pkg::NO_LINK) sh_tail[l] = p[NODE_W-1:0];
      end else begin
         sh_prev[s] = p;
      end
      return s;
   endfunction

   function automatic bit walk_matches(int l, bit fwd);
      logic [PTR_W-1:0] cur;
      int               seen;
      seen = 0;
      cur = (sh_len[l] == 0) ? dll_pkg::NO_LINK
                             : PTR_W'(fwd ? sh_head[l] : sh_tail[l]);
      while (cur != dll_pkg::NO_LINK) begin
         seen++;
         if (seen > sh_len[l]) return 1'b0;
         cur = as_link(fwd ? sh_next[cur] : sh_prev[cur]);
      end
      return seen == sh_len[l];
   endfunction

   function automatic void clear_list(int l);
      sh_head[l] = '0;
      sh_tail[l] = '0;
      sh_len[l]  = '0;
   endfunction

   // applies one request to the mirror and returns the expected response
   function automatic list_rsp_type apply_list_op(list_req_type r);
      list_rsp_type     e;
      logic [PTR_W-1:0] v;
      int               l;
      int               n;
      int               i;
      l = r.lid;
      e.st = dll_pkg::ST_NONE;
      e.node = '0;
      case (r.op)
         dll_pkg::OP_APPEND, dll_pkg::OP_INSERT: begin
            if (sh_len[l] < dll_pkg::POOL_CNT) begin
               if (r.op == dll_pkg::OP_APPEND) push_tail(l, r.node);
               else push_head(l, r.node);
               e.st = dll_pkg::ST_OK;
               e.node = r.node;
            end
         end
         dll_pkg::OP_DEL_NODE: begin
            if (sh_len[l] != 0) begin
               v = cut_node(l, r.node);
               if (v != dll_pkg::NO_LINK) begin
                  e.st = dll_pkg::ST_OK;
                  e.node = v[NODE_W-1:0];
               end
            end
         end
         dll_pkg::OP_DEL_HEAD, dll_pkg::OP_DEL_TAIL: begin
            if (sh_len[l] != 0) begin
               n = (r.op == dll_pkg::OP_DEL_HEAD) ? sh_head[l] : sh_tail[l];
               void'(cut_node(l, n));
               e.st = dll_pkg::ST_OK;
               e.node = NODE_W'(n);
            end
         end
         dll_pkg::OP_HEAD, dll_pkg::OP_TAIL: begin
            if (sh_len[l] != 0) begin
               e.st = dll_pkg::ST_OK;
               e.node = (r.op == dll_pkg::OP_HEAD) ? sh_head[l] : sh_tail[l];
            end
         end
         dll_pkg::OP_NTH: begin
            if (r.pos < sh_len[l]) begin
               v = PTR_W'(sh_head[l]);
               for (i = 0; i < r.pos && v != dll_pkg::NO_LINK; i++) v = as_link(sh_next[v]);
               if (v != dll_pkg::NO_LINK) begin
                  e.st = dll_pkg::ST_OK;
                  e.node = v[NODE_W-1:0];
               end
            end
         end
         dll_pkg::OP_NEXT, dll_pkg::OP_PREV: begin
            v = as_link((r.op == dll_pkg::OP_NEXT) ? sh_next[r.node] : sh_prev[r.node]);
            if (v != dll_pkg::NO_LINK) begin
               e.st = dll_pkg::ST_OK;
               e.node = v[NODE_W-1:0];
            end
         end
         dll_pkg::OP_COUNT: e.st = dll_pkg::ST_OK;
         dll_pkg::OP_CLEAR: begin
            clear_list(l);
            e.st = dll_pkg::ST_OK;
         end
         dll_pkg::OP_CHECK: e.st = (walk_matches(l, 1'b1) && walk_matches(l, 1'b0)) ?
                                   dll_pkg::ST_OK : dll_pkg::ST_BAD;
         dll_pkg::OP_FILL: begin
            n = POOL_NODES - r.node;
            if (r.pos < n) n = r.pos;
            clear_list(l);
            for (i = 0; i < n; i++) push_tail(l, r.node + i);
            e.st = dll_pkg::ST_OK;
         end
         default: ;
      endcase
      e.cnt = sh_len[l];
      return e;
   endfunction

   // some node of the list, found by walking from the head
   function automatic int list_member(int l);
      logic [PTR_W-1:0] v;
      logic [PTR_W-1:0] s;
      int               k;
      v = PTR_W'(sh_head[l]);
      k = $urandom_range(0, sh_len[l] - 1);
      repeat (k) begin
         s = as_link(sh_next[v]);
         if (s == dll_pkg::NO_LINK) break;
         v = s;
      end
      return v;
   endfunction

   function automatic list_req_type random_list_op();
      list_req_type r;
      int           w;
      r.lid  = LIST_W'($urandom_range(0, LIST_COUNT - 1));
      r.node = ($urandom_range(0, 7) == 0) ? NODE_W'($urandom_range(0, POOL_NODES - 1))
                                           : NODE_W'($urandom_range(0, 63));
      r.pos  = CNT_W'($urandom_range(0, 2047));
      w = $urandom_range(0, 99);
      if      (w < 22) r.op = dll_pkg::OP_APPEND;
      else if (w < 34) r.op = dll_pkg::OP_INSERT;
      else if (w < 44) r.op = dll_pkg::OP_DEL_NODE;
      else if (w < 50) r.op = dll_pkg::OP_DEL_HEAD;
      else if (w < 56) r.op = dll_pkg::OP_DEL_TAIL;
      else if (w < 60) r.op = dll_pkg::OP_HEAD;
      else if (w < 64) r.op = dll_pkg::OP_TAIL;
      else if (w < 72) r.op = dll_pkg::OP_NTH;
      else if (w < 78) r.op = dll_pkg::OP_NEXT;
      else if (w < 84) r.op = dll_pkg::OP_PREV;
      else if (w < 87) r.op = dll_pkg::OP_COUNT;
      else if (w < 90) r.op = dll_pkg::OP_CLEAR;
      else if (w < 95) r.op = dll_pkg::OP_CHECK;
      else if (w < 99) r.op = dll_pkg::OP_FILL;
      else r.op = OP_W'($urandom_range(14, 15));
      // link reads only on nodes that have been linked before
      if (r.op inside {dll_pkg::OP_DEL_NODE, dll_pkg::OP_NEXT, dll_pkg::OP_PREV}) begin
         if (linked_nodes.size() == 0) r.op = dll_pkg::OP_APPEND;
         else if (sh_len[r.lid] != 0 && $urandom_range(0, 9) < 7)
            r.node = NODE_W'(list_member(r.lid));
         else
            r.node = NODE_W'(linked_nodes[$urandom_range(0, linked_nodes.size() - 1)]);
      end
      if (r.op == dll_pkg::OP_NTH && $urandom_range(0, 7) != 0)
         r.pos = CNT_W'($urandom_range(0, sh_len[r.lid] + 2));
      if (r.op == dll_pkg::OP_FILL && $urandom_range(0, 29) != 0)
         r.pos = CNT_W'($urandom_range(0, 24));
      return r;
   endfunction

   // hands one transaction to the driver and waits until it is taken
   task automatic issue(list_req_type r);
      pending_reqs.push_back(r);
      n_queued++;
      wait (n_taken == n_queued);
   endtask

   task automatic issue_op(logic [OP_W-1:0] op, int l, int n, int p);
      list_req_type r;
      r.op = op;
      r.lid = LIST_W'(l);
      r.node = NODE_W'(n);
      r.pos = CNT_W'(p);
      issue(r);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_list_op(in_flight));
            n_taken++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transaction
         end else if (req_gap > 0 && !quiet) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            in_flight = pending_reqs.pop_front();
            req_opcode <= in_flight.op;
            req_list_id <= in_flight.lid;
            req_node_index <= in_flight.node;
            req_position <= in_flight.pos;
            req_valid <= 1'b1;
            req_gap <= idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      list_rsp_type e;
      int           k;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response transaction with nothing expected");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.st) begin
                  $error("status: expected %0d, got %0d", e.st, rsp_status);
                  errors++;
               end
               if (rsp_result_node !== e.node) begin
                  $error("result_node: expected %0d, got %0d", e.node, rsp_result_node);
                  errors++;
               end
               if (rsp_list_count !== e.cnt) begin
                  $error("list_count: expected %0d, got %0d", e.cnt, rsp_list_count);
                  errors++;
               end
            end
         end
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            k = idle_len();
            rsp_stall <= (k != 0);
            stall_left <= (k != 0) ? k - 1 : 0;
         end
      end
   end

   initial begin
      int i;
      foreach (sh_len[l]) clear_list(l);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, every opcode, refusals and clamping
      issue_op(dll_pkg::OP_HEAD, 0, 0, 0);
      issue_op(dll_pkg::OP_DEL_TAIL, 0, 0, 0);
      issue_op(dll_pkg::OP_DEL_NODE, 0, 3, 0);
      issue_op(dll_pkg::OP_NTH, 0, 0, 0);
      issue_op(dll_pkg::OP_APPEND, 0, 0, 0);
      issue_op(dll_pkg::OP_APPEND, 0, 1023, 2047);
      issue_op(dll_pkg::OP_INSERT, 0, 512, 0);
      issue_op(dll_pkg::OP_NTH, 0, 0, 2);
      issue_op(dll_pkg::OP_NTH, 0, 0, 1024);
      issue_op(dll_pkg::OP_NEXT, 0, 512, 0);
      issue_op(dll_pkg::OP_PREV, 0, 512, 0);
      issue_op(dll_pkg::OP_NEXT, 0, 1023, 0);
      issue_op(dll_pkg::OP_DEL_NODE, 0, 0, 0);
      issue_op(dll_pkg::OP_DEL_NODE, 0, 1023, 0);
      issue_op(dll_pkg::OP_COUNT, 0, 0, 0);
      issue_op(dll_pkg::OP_CHECK, 0, 0, 0);
      issue_op(4'd14, 0, 0, 0);
      issue_op(4'd15, 3, 1023, 2047);
      issue_op(dll_pkg::OP_FILL, 1, 1020, 10);
      issue_op(dll_pkg::OP_TAIL, 1, 0, 0);
      issue_op(dll_pkg::OP_DEL_HEAD, 1, 0, 0);
      issue_op(dll_pkg::OP_DEL_TAIL, 1, 0, 0);
      issue_op(dll_pkg::OP_FILL, 2, 0, 1024);
      issue_op(dll_pkg::OP_APPEND, 2, 5, 0);
      issue_op(dll_pkg::OP_INSERT, 2, 6, 0);
      issue_op(dll_pkg::OP_CHECK, 2, 0, 0);
      issue_op(dll_pkg::OP_CLEAR, 2, 0, 0);
      issue_op(dll_pkg::OP_FILL, 3, 7, 0);

      // random traffic with quiet stretches, one full drain part-way
      for (i = 0; i < 1350; i++) begin
         if (i == 600) wait (expected_rsps.size() == 0);
         quiet = (i % 300) < 50;
         issue(random_list_op());
      end
      quiet = 1'b0;

      wait (expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("PASS doubly_linked_list_engine");
      else
         $display("FAIL doubly_linked_list_engine");
      $finish;
   end

endmodule

`default_nettype wire
